FILE: rtl/core/kse_pkg.sv
package kse_pkg;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_SELECTING = 2'd1,
        MODE_CHANGING  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DETENT = 2'd1,
        ST_FINISH = 2'd2
    } t_state;

    localparam logic [1:0]  BTN_CLICK        = 2'd1;
    localparam logic [1:0]  BTN_DOUBLE       = 2'd2;

    localparam logic [15:0] STEP_COARSE      = 16'd100;
    localparam logic [15:0] STEP_FINE        = 16'd10;
    localparam logic [15:0] CURRENT_RESET    = 16'd1000;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd200;

endpackage

FILE: rtl/core/kse_if.sv
interface kse_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  turns;
    logic [1:0]  button_event;
    logic        new_voltage_valid;
    logic [15:0] new_voltage;
    logic        new_current_valid;
    logic [15:0] new_current;

    modport source (
        output valid, action, turns, button_event,
               new_voltage_valid, new_voltage, new_current_valid, new_current,
        input  ready
    );
    modport sink (
        input  valid, action, turns, button_event,
               new_voltage_valid, new_voltage, new_current_valid, new_current,
        output ready
    );
endinterface

interface kse_out_if;
    logic        valid;
    logic        ready;
    logic        send_voltage;
    logic        send_current;
    logic [15:0] voltage_setpoint;
    logic [15:0] current_setpoint;
    logic [1:0]  cursor_mode;
    logic        cursor_on_current;

    modport source (
        output valid, send_voltage, send_current, voltage_setpoint,
               current_setpoint, cursor_mode, cursor_on_current,
        input  ready
    );
    modport sink (
        input  valid, send_voltage, send_current, voltage_setpoint,
               current_setpoint, cursor_mode, cursor_on_current,
        output ready
    );
endinterface

FILE: rtl/core/knob_setpoint_editor.sv
// channel   | dir | handshake      | payload
// i_item    | in  | valid / ready  | action, turns, button_event, new setpoints
// o_result  | out | valid / ready  | send flags, setpoints, cursor mode and entry
// i_cfg_*   | in  | write enable   | idle_timeout
//
// An update tick is done in its transfer cycle; an encoder item steps its |turns|
// detents one per cycle through the shared step adder.
// The result waits in an output register; no new transfer is taken until it
// has left, so a stalled output holds the input off.
// i_rst_n is synchronous and active low.
module knob_setpoint_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    kse_in_if.sink      i_item,
    kse_out_if.source   o_result
);

    kse_pkg::t_state r_state, n_state;
    kse_pkg::t_mode  r_mode, n_mode;
    logic        r_sel, n_sel;
    logic [15:0] r_volt, n_volt;
    logic [15:0] r_cur, n_cur;
    logic        r_pending, n_pending;
    logic [15:0] r_idle_count, n_idle_count;
    logic [15:0] r_idle_timeout;
    logic        r_out_valid, n_out_valid;
    logic        r_send_v, n_send_v;
    logic        r_send_i, n_send_i;
    logic [7:0]  r_count, n_count;
    logic        r_up, n_up;
    logic [15:0] r_v0, n_v0;
    logic [15:0] r_i0, n_i0;
    logic [1:0]  r_button, n_button;

    logic        w_accept;
    logic [15:0] w_sel_value;
    logic [15:0] w_stepped;

    assign w_sel_value = r_sel ? r_cur : r_volt;

    kse_step_unit u_step (
        .i_value (w_sel_value),
        .i_up    (r_up),
        .o_value (w_stepped)
    );

    assign i_item.ready = (r_state == kse_pkg::ST_IDLE) && !r_out_valid;
    assign w_accept     = i_item.valid && i_item.ready;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_sel        = r_sel;
        n_volt       = r_volt;
        n_cur        = r_cur;
        n_pending    = r_pending;
        n_idle_count = r_idle_count;
        n_out_valid  = r_out_valid;
        n_send_v     = r_send_v;
        n_send_i     = r_send_i;
        n_count      = r_count;
        n_up         = r_up;
        n_v0         = r_v0;
        n_i0         = r_i0;
        n_button     = r_button;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            kse_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (!i_item.action) begin
                        n_up     = !i_item.turns[7];
                        n_count  = i_item.turns[7] ? (8'd0 - i_item.turns) : i_item.turns;
                        n_v0     = r_volt;
                        n_i0     = r_cur;
                        n_button = i_item.button_event;
                        n_state  = kse_pkg::ST_DETENT;
                    end else begin
                        // update tick, done in the transfer cycle
                        if (i_item.new_voltage_valid) begin
                            n_volt = i_item.new_voltage;
                        end
                        if (i_item.new_current_valid) begin
                            n_cur = i_item.new_current;
                        end
                        if (r_pending) begin
                            if (r_mode == kse_pkg::MODE_OFF) begin
                                n_mode = kse_pkg::MODE_SELECTING;
                            end
                            n_idle_count = 16'd0;
                            n_pending    = 1'b0;
                        end else if (r_idle_count < r_idle_timeout) begin
                            n_idle_count = r_idle_count + 16'd1;
                        end
                        if (n_idle_count >= r_idle_timeout) begin
                            n_mode = kse_pkg::MODE_OFF;
                        end
                        n_send_v    = 1'b0;
                        n_send_i    = 1'b0;
                        n_out_valid = 1'b1;
                    end
                end
            end
            kse_pkg::ST_DETENT: begin
                if (r_count == 8'd0) begin
                    n_state = kse_pkg::ST_FINISH;
                end else begin
                    n_count   = r_count - 8'd1;
                    n_pending = 1'b1;
                    unique case (r_mode)
                        kse_pkg::MODE_SELECTING: n_sel = !r_sel;
                        kse_pkg::MODE_CHANGING: begin
                            if (r_sel) begin
                                n_cur = w_stepped;
                            end else begin
                                n_volt = w_stepped;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            kse_pkg::ST_FINISH: begin
                if (r_button == kse_pkg::BTN_CLICK) begin
                    if (r_mode == kse_pkg::MODE_SELECTING) begin
                        n_mode = kse_pkg::MODE_CHANGING;
                    end else if (r_mode == kse_pkg::MODE_CHANGING) begin
                        n_mode = kse_pkg::MODE_SELECTING;
                    end
                    n_pending = 1'b1;
                end else if (r_button == kse_pkg::BTN_DOUBLE) begin
                    n_pending = 1'b1;
                end
                n_send_v    = n_pending && (r_v0 != r_volt);
                n_send_i    = n_pending && (r_i0 != r_cur);
                n_out_valid = 1'b1;
                n_state     = kse_pkg::ST_IDLE;
            end
            default: n_state = kse_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= kse_pkg::ST_IDLE;
            r_mode         <= kse_pkg::MODE_OFF;
            r_sel          <= 1'b0;
            r_volt         <= 16'd0;
            r_cur          <= kse_pkg::CURRENT_RESET;
            r_pending      <= 1'b0;
            r_idle_count   <= 16'd0;
            r_idle_timeout <= kse_pkg::TIMEOUT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_sel        <= n_sel;
            r_volt       <= n_volt;
            r_cur        <= n_cur;
            r_pending    <= n_pending;
            r_idle_count <= n_idle_count;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_idle_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_send_v <= n_send_v;
        r_send_i <= n_send_i;
        r_count  <= n_count;
        r_up     <= n_up;
        r_v0     <= n_v0;
        r_i0     <= n_i0;
        r_button <= n_button;
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.send_voltage      = r_send_v;
    assign o_result.send_current      = r_send_i;
    assign o_result.voltage_setpoint  = r_volt;
    assign o_result.current_setpoint  = r_cur;
    assign o_result.cursor_mode       = r_mode;
    assign o_result.cursor_on_current = r_sel;

    // detent loop counts down by one each cycle
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kse_pkg::ST_DETENT && r_count != 8'd0)
        |=> (r_count == $past(r_count) - 8'd1))
        else $error("detent counter skipped");

    // an update tick yields a registered result, with no command flagged
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.action)
        |=> (o_result.valid && !o_result.send_voltage && !o_result.send_current))
        else $error("update tick result wrong");

    // no transfer while a result or an item is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> (!r_out_valid && r_state == kse_pkg::ST_IDLE))
        else $error("ready with work outstanding");

    // set-voltage is only flagged when the voltage moved during the item
    a_send_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kse_pkg::ST_FINISH && r_v0 == r_volt) |=> !r_send_v)
        else $error("set-voltage flagged without change");

endmodule

FILE: rtl/core/kse_step_unit.sv
module kse_step_unit (
    input  logic [15:0] i_value,
    input  logic        i_up,
    output logic [15:0] o_value
);

    logic        w_coarse;
    logic        w_fine;
    logic        w_apply;
    logic [15:0] w_delta;
    logic [15:0] w_addend;

    // one adder serves both directions; a decrease adds the two's complement
    always_comb begin
        w_coarse = (i_value > kse_pkg::STEP_COARSE);
        w_fine   = (i_value > kse_pkg::STEP_FINE);
        w_delta  = w_coarse ? kse_pkg::STEP_COARSE : kse_pkg::STEP_FINE;
        w_apply  = i_up || w_coarse || w_fine;
        w_addend = i_up ? w_delta : (16'd0 - w_delta);
        o_value  = w_apply ? (i_value + w_addend) : i_value;
    end

endmodule
